// ----- hw/rtl/spq_pkg.sv -----
// Package for the sorted-list priority queue.
// Holds field widths, operation and status codes, and the control struct
// that the top level broadcasts to every cell. No dependencies.
package spq_pkg;

  localparam int KEY_W     = 32;
  localparam int OCC_W     = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to all cells for the current transfer
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_insert_pop_min_list.sv -----
// Sorted-list priority queue built as a chain of compare-and-shift cells.
// Each accepted transfer's result is captured in the output register.
// Throughput: 1 item per cycle; every cell compares and shifts in the same
// cycle, and the output register takes a new result while m_tvalid is low or m_tready is high.
// Reset (rst, synchronous) empties the list and clears the output valid;
// stored keys are not cleared.
module sorted_insert_pop_min_list import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [KEY_W-1:0]  s_tdata,   // [31:0] key_in
  input  logic [0:0]        s_tuser,   // [0] op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [31:0] key_out, [36:32] occupancy, zero above
  output logic [1:0]        m_tuser    // [1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  op_t                     op;
  cell_ctrl_t              ctrl;
  status_t                 status_next;
  logic signed [KEY_W-1:0] keys [DEPTH];
  logic                    lts  [DEPTH];

  logic signed [KEY_W-1:0] out_key;
  logic [OCC_W-1:0]        out_occ;
  status_t                 out_status;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser[0]);
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;

  always_comb begin
    ctrl.ins    = accept && (op == OP_INSERT) && !full;
    ctrl.rem    = accept && (op == OP_REMOVE) && !empty;
    ctrl.key    = s_tdata;
    count_next  = count;
    status_next = ST_OK;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
    if (op == OP_INSERT && full) begin
      status_next = ST_FULL;
    end else if (op == OP_REMOVE && empty) begin
      status_next = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = '0;
    end else begin : g_mid
      assign left_lt  = lts[i-1];
      assign left_key = keys[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_body
      assign right_key = keys[i+1];
    end

    spq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[i]),
      .lt        (lts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key    <= ctrl.rem ? keys[0] : '0;
      out_occ    <= OCC_W'(count_next);
      out_status <= status_next;
    end
  end

  assign m_tdata = {3'b000, out_occ, out_key};
  assign m_tuser = out_status;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One entry of the sorted list: holds a key and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int INDEX = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [CW-1:0]           count,
  input  logic                    left_lt,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key,
  output logic                    lt
);

  logic                    own_valid;
  logic signed [KEY_W-1:0] key_next;

  assign own_valid = count > CW'(INDEX);
  // entry stays put on insert when it is strictly below the new key
  assign lt        = own_valid && (key < ctrl.key);

  always_comb begin
    key_next = key;
    if (ctrl.ins) begin
      if (lt) begin
        key_next = key;
      end else if (left_lt) begin
        key_next = ctrl.key;
      end else begin
        key_next = left_key;
      end
    end else if (ctrl.rem) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule
